// ----- sv/ps2_mouse_packet_tracker_defines.svh -----
// assertion helpers used by the tracker module
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PMPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PMPT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/pmpt_pkg.sv -----
package pmpt_pkg;

   // default widths of cursor and wheel state
   localparam int COORD_WIDTH_DEF = 12;
   localparam int WHEEL_WIDTH_DEF = 16;

   // fixed field widths
   localparam int BYTE_WIDTH      = 8;
   localparam int MAX_WIDTH       = 12;
   localparam int WHEEL_OUT_WIDTH = 16;
   localparam int BUTTON_WIDTH    = 5;
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH  = 32;

   // device ids with 4-byte packets
   localparam logic [BYTE_WIDTH-1:0] ID_WHEEL    = 8'h03;
   localparam logic [BYTE_WIDTH-1:0] ID_FIVE_BTN = 8'h04;

   // register indexes
   localparam logic [1:0] REG_DEVICE_ID = 2'd0;
   localparam logic [1:0] REG_MAX_X     = 2'd1;
   localparam logic [1:0] REG_MAX_Y     = 2'd2;

   // reset values
   localparam logic [BYTE_WIDTH-1:0] DEVICE_ID_RST = 8'h00;
   localparam logic [MAX_WIDTH-1:0]  MAX_X_RST     = 12'd799;
   localparam logic [MAX_WIDTH-1:0]  MAX_Y_RST     = 12'd599;
   localparam int                    POS_X_RST     = 40;
   localparam int                    POS_Y_RST     = 12;

   // acceleration thresholds
   localparam logic signed [9:0] ACCEL_HIGH = 10'sd5;
   localparam logic signed [9:0] ACCEL_LOW  = 10'sd3;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] device_id;
      logic [MAX_WIDTH-1:0]  max_x;
      logic [MAX_WIDTH-1:0]  max_y;
   } cfg_type;

   // signed delta byte with acceleration: x3 above 5, x2 above 3
   function automatic logic signed [9:0] accel(input logic [BYTE_WIDTH-1:0] b);
      logic signed [9:0] d;
      logic signed [9:0] r;
      d = 10'(signed'(b));
      if (d > ACCEL_HIGH || d < -ACCEL_HIGH) begin
         r = d * 10'sd3;
      end else if (d > ACCEL_LOW || d < -ACCEL_LOW) begin
         r = d * 10'sd2;
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

// ----- sv/pmpt_csr.sv -----
module pmpt_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [pmpt_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [pmpt_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [pmpt_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready,
   output pmpt_pkg::cfg_type                      cfg
);

   pmpt_pkg::cfg_type cfg_ff;
   pmpt_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            pmpt_pkg::REG_DEVICE_ID:
               cfg_in.device_id = csr_pwdata[pmpt_pkg::BYTE_WIDTH-1:0];
            pmpt_pkg::REG_MAX_X:
               cfg_in.max_x = csr_pwdata[pmpt_pkg::MAX_WIDTH-1:0];
            pmpt_pkg::REG_MAX_Y:
               cfg_in.max_y = csr_pwdata[pmpt_pkg::MAX_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_id <= pmpt_pkg::DEVICE_ID_RST;
         cfg_ff.max_x     <= pmpt_pkg::MAX_X_RST;
         cfg_ff.max_y     <= pmpt_pkg::MAX_Y_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         pmpt_pkg::REG_DEVICE_ID:
            csr_prdata = pmpt_pkg::CSR_DATA_WIDTH'(cfg_ff.device_id);
         pmpt_pkg::REG_MAX_X:
            csr_prdata = pmpt_pkg::CSR_DATA_WIDTH'(cfg_ff.max_x);
         pmpt_pkg::REG_MAX_Y:
            csr_prdata = pmpt_pkg::CSR_DATA_WIDTH'(cfg_ff.max_y);
         default:
            csr_prdata = '0;
      endcase
   end

endmodule

// ----- sv/ps2_mouse_packet_tracker.sv -----
// a byte that ends a packet passes through the input stage and then the result register
// throughput: one byte per cycle while no stall holds it, set by the single input stage and result register
// a pending result that is stalled holds back only a byte that would end a packet
// reset (synchronous, active high) clears the packet index, cursor (40,12), wheel and buttons
// and loads device id 0, max x 799, max y 599; no clearing pass is needed
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2_mouse_packet_tracker #(
   parameter int COORD_WIDTH = pmpt_pkg::COORD_WIDTH_DEF,
   parameter int WHEEL_WIDTH = pmpt_pkg::WHEEL_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [pmpt_pkg::BYTE_WIDTH-1:0]             req_data_byte,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [COORD_WIDTH-1:0]                      rsp_cursor_x,
   output logic [COORD_WIDTH-1:0]                      rsp_cursor_y,
   output logic signed [pmpt_pkg::WHEEL_OUT_WIDTH-1:0] rsp_wheel_position,
   output logic [pmpt_pkg::BUTTON_WIDTH-1:0]           rsp_button_bits,
   output logic                                        rsp_moved,
   input  logic                                        csr_psel,
   input  logic                                        csr_penable,
   input  logic                                        csr_pwrite,
   input  logic [pmpt_pkg::CSR_ADDR_WIDTH-1:0]         csr_paddr,
   input  logic [pmpt_pkg::CSR_DATA_WIDTH-1:0]         csr_pwdata,
   output logic [pmpt_pkg::CSR_DATA_WIDTH-1:0]         csr_prdata,
   output logic                                        csr_pready
);

   localparam int SUM_W = COORD_WIDTH + 3;

   pmpt_pkg::cfg_type cfg;

   // input stage
   logic                            in_valid_ff;
   logic                            in_valid_in;
   logic [pmpt_pkg::BYTE_WIDTH-1:0] in_byte_ff;

   // packet and cursor state
   logic [1:0]                        byte_index_ff;
   logic [1:0]                        byte_index_in;
   logic [pmpt_pkg::BYTE_WIDTH-1:0]   pb_ff [3];
   logic [COORD_WIDTH-1:0]            pos_x_ff;
   logic [COORD_WIDTH-1:0]            pos_x_in;
   logic [COORD_WIDTH-1:0]            pos_y_ff;
   logic [COORD_WIDTH-1:0]            pos_y_in;
   logic signed [WHEEL_WIDTH-1:0]     wheel_ff;
   logic signed [WHEEL_WIDTH-1:0]     wheel_in;
   logic [pmpt_pkg::BUTTON_WIDTH-1:0] button_ff;
   logic [pmpt_pkg::BUTTON_WIDTH-1:0] button_in;

   // result register
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [COORD_WIDTH-1:0]                      rsp_x_ff;
   logic [COORD_WIDTH-1:0]                      rsp_y_ff;
   logic signed [pmpt_pkg::WHEEL_OUT_WIDTH-1:0] rsp_wheel_ff;
   logic [pmpt_pkg::BUTTON_WIDTH-1:0]           rsp_button_ff;
   logic                                        rsp_moved_ff;

   // datapath
   logic                                wheel_mode;
   logic                                last;
   logic                                advance;
   logic                                proc;
   logic                                out_load;
   logic [pmpt_pkg::BYTE_WIDTH-1:0]     b0;
   logic [pmpt_pkg::BYTE_WIDTH-1:0]     b1;
   logic [pmpt_pkg::BYTE_WIDTH-1:0]     b2;
   logic signed [9:0]                   dx;
   logic signed [9:0]                   dy;
   logic signed [SUM_W-1:0]             sum_x;
   logic signed [SUM_W-1:0]             sum_y;
   logic [COORD_WIDTH-1:0]              max_x_cw;
   logic [COORD_WIDTH-1:0]              max_y_cw;
   logic signed [SUM_W-1:0]             max_x_ext;
   logic signed [SUM_W-1:0]             max_y_ext;
   logic signed [pmpt_pkg::BYTE_WIDTH-1:0] wheel_delta;

   pmpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // packet framing
   assign wheel_mode = (cfg.device_id == pmpt_pkg::ID_WHEEL) ||
                       (cfg.device_id == pmpt_pkg::ID_FIVE_BTN);
   assign last       = (byte_index_ff == 2'd3) || ((byte_index_ff == 2'd2) && !wheel_mode);

   // handshake: only a packet-ending item waits on a stalled result
   assign advance   = !(last && rsp_valid_ff && rsp_stall);
   assign proc      = in_valid_ff && advance;
   assign out_load  = proc && last;
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // packet bytes including the one in flight
   assign b0 = (byte_index_ff == 2'd0) ? in_byte_ff : pb_ff[0];
   assign b1 = (byte_index_ff == 2'd1) ? in_byte_ff : pb_ff[1];
   assign b2 = (byte_index_ff == 2'd2) ? in_byte_ff : pb_ff[2];

   assign dx = pmpt_pkg::accel(b1);
   assign dy = pmpt_pkg::accel(b2);

   // cursor update and clamp
   assign max_x_cw  = COORD_WIDTH'(cfg.max_x);
   assign max_y_cw  = COORD_WIDTH'(cfg.max_y);
   assign max_x_ext = SUM_W'(signed'({1'b0, max_x_cw}));
   assign max_y_ext = SUM_W'(signed'({1'b0, max_y_cw}));
   assign sum_x = SUM_W'(signed'({1'b0, pos_x_ff})) + SUM_W'(dx);
   assign sum_y = SUM_W'(signed'({1'b0, pos_y_ff})) - SUM_W'(dy);

   always_comb begin
      if (sum_x < 0) begin
         pos_x_in = '0;
      end else if (sum_x > max_x_ext) begin
         pos_x_in = max_x_cw;
      end else begin
         pos_x_in = sum_x[COORD_WIDTH-1:0];
      end
      if (sum_y < 0) begin
         pos_y_in = '0;
      end else if (sum_y > max_y_ext) begin
         pos_y_in = max_y_cw;
      end else begin
         pos_y_in = sum_y[COORD_WIDTH-1:0];
      end
   end

   // wheel delta per device id
   always_comb begin
      if (cfg.device_id == pmpt_pkg::ID_WHEEL) begin
         wheel_delta = signed'(in_byte_ff);
      end else if (cfg.device_id == pmpt_pkg::ID_FIVE_BTN) begin
         wheel_delta = pmpt_pkg::BYTE_WIDTH'(signed'(in_byte_ff[3:0]));
      end else begin
         wheel_delta = '0;
      end
   end
   assign wheel_in = wheel_ff - WHEEL_WIDTH'(wheel_delta);

   // buttons 4 and 5 only follow the last byte in five-button mode
   always_comb begin
      if (cfg.device_id == pmpt_pkg::ID_FIVE_BTN) begin
         button_in = {in_byte_ff[5], in_byte_ff[4], b0[2:0]};
      end else begin
         button_in = {button_ff[4:3], b0[2:0]};
      end
   end

   assign byte_index_in = last ? 2'd0 : byte_index_ff + 2'd1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byte_index_ff <= 2'd0;
         pos_x_ff      <= COORD_WIDTH'(pmpt_pkg::POS_X_RST);
         pos_y_ff      <= COORD_WIDTH'(pmpt_pkg::POS_Y_RST);
         wheel_ff      <= '0;
         button_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc) begin
            byte_index_ff <= byte_index_in;
         end
         if (out_load) begin
            pos_x_ff  <= pos_x_in;
            pos_y_ff  <= pos_y_in;
            wheel_ff  <= wheel_in;
            button_ff <= button_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (proc && (byte_index_ff != 2'd3)) begin
         pb_ff[byte_index_ff] <= in_byte_ff;
      end
      if (out_load) begin
         rsp_x_ff      <= pos_x_in;
         rsp_y_ff      <= pos_y_in;
         rsp_wheel_ff  <= pmpt_pkg::WHEEL_OUT_WIDTH'(wheel_in);
         rsp_button_ff <= button_in;
         rsp_moved_ff  <= (pos_x_in != pos_x_ff) || (pos_y_in != pos_y_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_x       = rsp_x_ff;
   assign rsp_cursor_y       = rsp_y_ff;
   assign rsp_wheel_position = rsp_wheel_ff;
   assign rsp_button_bits    = rsp_button_ff;
   assign rsp_moved          = rsp_moved_ff;

   // checks
   `PMPT_ASSERT_NXT(a_index_restart, clock, reset, out_load, byte_index_ff == 2'd0, "index not restarted after packet")
   `PMPT_ASSERT_IMP(a_cursor_x_clamped, clock, reset, rsp_valid_ff, (rsp_x_ff <= max_x_cw) || (rsp_x_ff == '0), "cursor x beyond max")
   `PMPT_ASSERT_IMP(a_cursor_y_clamped, clock, reset, rsp_valid_ff, (rsp_y_ff <= max_y_cw) || (rsp_y_ff == '0), "cursor y beyond max")
   `PMPT_ASSERT_NXT(a_stage_held, clock, reset, in_valid_ff && req_stall, in_valid_ff && $stable(in_byte_ff), "held input item lost")

endmodule

// ----- tb/tb_ps2_mouse_packet_tracker.sv -----
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_tracker;

   localparam int COORD_W   = pmpt_pkg::COORD_WIDTH_DEF;
   localparam int HOLD_LEN  = 150;
   localparam int SETTLE    = 4;
   localparam int PHASES    = 8;
   localparam int PHASE_LEN = 100;

   typedef struct {
      logic [COORD_W-1:0]                          cursor_x;
      logic [COORD_W-1:0]                          cursor_y;
      logic signed [pmpt_pkg::WHEEL_OUT_WIDTH-1:0] wheel_position;
      logic [pmpt_pkg::BUTTON_WIDTH-1:0]           button_bits;
      logic                                        moved;
   } cursor_report_type;

   logic                                        clock;
   logic                                        reset;
   logic                                        req_valid;
   logic                                        req_stall;
   logic [pmpt_pkg::BYTE_WIDTH-1:0]             req_data_byte;
   logic                                        rsp_valid;
   logic                                        rsp_stall = 1'b0;
   logic [COORD_W-1:0]                          rsp_cursor_x;
   logic [COORD_W-1:0]                          rsp_cursor_y;
   logic signed [pmpt_pkg::WHEEL_OUT_WIDTH-1:0] rsp_wheel_position;
   logic [pmpt_pkg::BUTTON_WIDTH-1:0]           rsp_button_bits;
   logic                                        rsp_moved;
   logic                                        csr_psel;
   logic                                        csr_penable;
   logic                                        csr_pwrite;
   logic [pmpt_pkg::CSR_ADDR_WIDTH-1:0]         csr_paddr;
   logic [pmpt_pkg::CSR_DATA_WIDTH-1:0]         csr_pwdata;
   logic [pmpt_pkg::CSR_DATA_WIDTH-1:0]         csr_prdata;
   logic                                        csr_pready;

   // tracker state as the testbench sees it
   logic [pmpt_pkg::BYTE_WIDTH-1:0]      cfg_id;
   logic [pmpt_pkg::MAX_WIDTH-1:0]       cfg_max_x;
   logic [pmpt_pkg::MAX_WIDTH-1:0]       cfg_max_y;
   logic [1:0]                           pkt_index;
   logic [pmpt_pkg::BYTE_WIDTH-1:0]      pkt_bytes [3];
   logic [COORD_W-1:0]                   cur_x;
   logic [COORD_W-1:0]                   cur_y;
   logic [pmpt_pkg::WHEEL_WIDTH_DEF-1:0] wheel_cnt;
   logic [pmpt_pkg::BUTTON_WIDTH-1:0]    btn_state;

   cursor_report_type pending_reports [$];
   int errors = 0;

   // pacing controls
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int hold_requests = 0;
   int hold_seen = 0;
   int stall_left = 0;
   int stall_roll;

   ps2_mouse_packet_tracker i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cursor_x       (rsp_cursor_x),
      .rsp_cursor_y       (rsp_cursor_y),
      .rsp_wheel_position (rsp_wheel_position),
      .rsp_button_bits    (rsp_button_bits),
      .rsp_moved          (rsp_moved),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // acceleration of one signed delta byte
   function automatic int boost(input logic [pmpt_pkg::BYTE_WIDTH-1:0] b);
      int d;
      int m;
      d = int'($signed(b));
      m = (d < 0) ? -d : d;
      if (m > 5) return d * 3;
      if (m > 3) return d * 2;
      return d;
   endfunction

   function automatic int limit(input int v, input logic [pmpt_pkg::MAX_WIDTH-1:0] top);
      if (v > int'(top)) v = int'(top);
      if (v < 0) v = 0;
      return v;
   endfunction

   function automatic logic [pmpt_pkg::CSR_ADDR_WIDTH-1:0] reg_addr(input logic [1:0] idx);
      return {idx, 2'b00};
   endfunction

   task automatic reset_tracker();
      cfg_id    = pmpt_pkg::DEVICE_ID_RST;
      cfg_max_x = pmpt_pkg::MAX_X_RST;
      cfg_max_y = pmpt_pkg::MAX_Y_RST;
      pkt_index = 2'd0;
      cur_x     = COORD_W'(pmpt_pkg::POS_X_RST);
      cur_y     = COORD_W'(pmpt_pkg::POS_Y_RST);
      wheel_cnt = '0;
      btn_state = '0;
   endtask

   // advance the packet tracker by one byte, queue a cursor report at packet end
   task automatic track_byte(input logic [pmpt_pkg::BYTE_WIDTH-1:0] b);
      int idx;
      int count;
      int dx;
      int dy;
      int spin;
      int nx;
      int ny;
      logic [3:0] nib;
      cursor_report_type rep;
      idx = int'(pkt_index);
      count = (cfg_id == pmpt_pkg::ID_WHEEL || cfg_id == pmpt_pkg::ID_FIVE_BTN) ? 4 : 3;
      if (idx < 3) pkt_bytes[idx] = b;
      if (idx + 1 < count) begin
         pkt_index = 2'(idx + 1);
         return;
      end
      pkt_index = 2'd0;
      dx = boost(pkt_bytes[1]);
      dy = boost(pkt_bytes[2]);
      // wheel: full signed byte or signed low nibble
      spin = 0;
      if (cfg_id == pmpt_pkg::ID_WHEEL) begin
         spin = int'($signed(b));
      end else if (cfg_id == pmpt_pkg::ID_FIVE_BTN) begin
         nib = b[3:0];
         spin = int'($signed(nib));
      end
      wheel_cnt = wheel_cnt - pmpt_pkg::WHEEL_WIDTH_DEF'(spin);
      // buttons 1 to 3 always, 4 and 5 only in five-button mode
      btn_state = {btn_state[4:3], pkt_bytes[0][2:0]};
      if (cfg_id == pmpt_pkg::ID_FIVE_BTN) btn_state[4:3] = {b[5], b[4]};
      nx = limit(int'(cur_x) + dx, cfg_max_x);
      ny = limit(int'(cur_y) - dy, cfg_max_y);
      rep.moved = (nx != int'(cur_x)) || (ny != int'(cur_y));
      cur_x = COORD_W'(nx);
      cur_y = COORD_W'(ny);
      rep.cursor_x = cur_x;
      rep.cursor_y = cur_y;
      rep.wheel_position = pmpt_pkg::WHEEL_OUT_WIDTH'($signed(wheel_cnt));
      rep.button_bits = btn_state;
      pending_reports.push_back(rep);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val,
                  act_val);
         errors++;
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (!req_idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // send one byte, with a random gap ahead of it while req_idle_on is set
   task automatic send_byte(input logic [pmpt_pkg::BYTE_WIDTH-1:0] b);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      track_byte(b);
   endtask

   // stop sending and let every queued report come out
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write followed by a read back
   task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= reg_addr(idx);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         pmpt_pkg::REG_DEVICE_ID: cfg_id = value[pmpt_pkg::BYTE_WIDTH-1:0];
         pmpt_pkg::REG_MAX_X:     cfg_max_x = value[pmpt_pkg::MAX_WIDTH-1:0];
         pmpt_pkg::REG_MAX_Y:     cfg_max_y = value[pmpt_pkg::MAX_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      case (idx)
         pmpt_pkg::REG_DEVICE_ID:
            check_field("device_id readback", 32'(cfg_id), readback);
         pmpt_pkg::REG_MAX_X:
            check_field("max_x readback", 32'(cfg_max_x), readback);
         pmpt_pkg::REG_MAX_Y:
            check_field("max_y readback", 32'(cfg_max_y), readback);
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // random byte, biased toward small deltas around the acceleration thresholds
   function automatic logic [pmpt_pkg::BYTE_WIDTH-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (pkt_index == 2'd1 || pkt_index == 2'd2) begin
         if (r < 40) return pmpt_pkg::BYTE_WIDTH'($urandom_range(0, 16) - 8);
         if (r < 45) return 8'h80;
         if (r < 50) return 8'h7F;
      end
      return pmpt_pkg::BYTE_WIDTH'($urandom_range(0, 255));
   endfunction

   // receiver stall pattern, with long holds on request
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         stall_left = HOLD_LEN;
      end else if (stall_left == 0 && rsp_idle_on) begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll >= 97) stall_left = $urandom_range(20, 60);
         else if (stall_roll >= 70) stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted report with the oldest expected one
   always @(posedge clock) begin
      cursor_report_type exp_rep;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none actual x=%0d y=%0d", $time,
                     rsp_cursor_x, rsp_cursor_y);
            errors++;
         end else begin
            exp_rep = pending_reports.pop_front();
            check_field("cursor_x", 32'(exp_rep.cursor_x), 32'(rsp_cursor_x));
            check_field("cursor_y", 32'(exp_rep.cursor_y), 32'(rsp_cursor_y));
            check_field("wheel_position", 32'(exp_rep.wheel_position),
                        32'(rsp_wheel_position));
            check_field("button_bits", 32'(exp_rep.button_bits), 32'(rsp_button_bits));
            check_field("moved", 32'(exp_rep.moved), 32'(rsp_moved));
         end
      end
   end

   // three-byte packets at reset settings: delta extremes and thresholds
   task automatic test_default_packets();
      send_byte(8'h07); send_byte(8'h7F); send_byte(8'h80);
      send_byte(8'hF8); send_byte(8'hFC); send_byte(8'h04);
      send_byte(8'h02); send_byte(8'h06); send_byte(8'hFB);
      wait_idle();
   endtask

   // wheel mode: signed byte wheel
   task automatic test_wheel_packets();
      set_reg(pmpt_pkg::REG_DEVICE_ID, 32'(pmpt_pkg::ID_WHEEL));
      send_byte(8'h09); send_byte(8'hFF); send_byte(8'h01); send_byte(8'h80);
      wait_idle();
   endtask

   // five-button mode: nibble wheel extremes, buttons 4 and 5 set then cleared
   task automatic test_five_button_packets();
      set_reg(pmpt_pkg::REG_DEVICE_ID, 32'(pmpt_pkg::ID_FIVE_BTN));
      send_byte(8'h03); send_byte(8'h00); send_byte(8'h00); send_byte(8'h38);
      send_byte(8'h00); send_byte(8'h01); send_byte(8'hFF); send_byte(8'hC7);
      wait_idle();
   endtask

   // packet length changes while a packet is open
   task automatic test_id_change_mid_packet();
      send_byte(8'h01); send_byte(8'h10); send_byte(8'hF0);
      wait_idle();
      set_reg(pmpt_pkg::REG_DEVICE_ID, 32'(pmpt_pkg::DEVICE_ID_RST));
      send_byte(8'h55);
      send_byte(8'h04); send_byte(8'h07);
      wait_idle();
      set_reg(pmpt_pkg::REG_DEVICE_ID, 32'(pmpt_pkg::ID_WHEEL));
      send_byte(8'hF9); send_byte(8'h7F);
      wait_idle();
   endtask

   // max below current position pulls the cursor in at packet end
   task automatic test_clamping();
      set_reg(pmpt_pkg::REG_DEVICE_ID, 32'(pmpt_pkg::DEVICE_ID_RST));
      set_reg(pmpt_pkg::REG_MAX_X, 32'd0);
      set_reg(pmpt_pkg::REG_MAX_Y, 32'd0);
      send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
      wait_idle();
   endtask

   // long receiver hold while bytes keep coming
   task automatic test_backpressure();
      set_reg(pmpt_pkg::REG_MAX_X, 32'd4095);
      set_reg(pmpt_pkg::REG_MAX_Y, 32'd4095);
      req_idle_on = 1'b0;
      hold_requests++;
      repeat (40) send_byte(pick_byte());
      wait_idle();
      req_idle_on = 1'b1;
   endtask

   // random phases over a spread of settings
   task automatic test_random_traffic();
      logic [pmpt_pkg::BYTE_WIDTH-1:0] ids [PHASES];
      logic [pmpt_pkg::MAX_WIDTH-1:0]  mx;
      logic [pmpt_pkg::MAX_WIDTH-1:0]  my;
      ids = '{8'h00, pmpt_pkg::ID_WHEEL, pmpt_pkg::ID_FIVE_BTN, 8'hFF,
              pmpt_pkg::ID_FIVE_BTN, pmpt_pkg::ID_WHEEL, 8'h00, 8'h00};
      ids[6] = pmpt_pkg::BYTE_WIDTH'($urandom_range(0, 255));
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1: begin mx = '0; my = '1; end
            2: begin mx = '1; my = '0; end
            5: begin
               mx = pmpt_pkg::MAX_WIDTH'($urandom_range(0, 30));
               my = pmpt_pkg::MAX_WIDTH'($urandom_range(0, 30));
            end
            default: begin
               mx = pmpt_pkg::MAX_WIDTH'($urandom_range(100, 4095));
               my = pmpt_pkg::MAX_WIDTH'($urandom_range(100, 4095));
            end
         endcase
         set_reg(pmpt_pkg::REG_DEVICE_ID, 32'(ids[p]));
         set_reg(pmpt_pkg::REG_MAX_X, 32'(mx));
         set_reg(pmpt_pkg::REG_MAX_Y, 32'(my));
         req_idle_on = (p != 3);
         rsp_idle_on = (p != 6);
         repeat (PHASE_LEN) send_byte(pick_byte());
         wait_idle();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset_tracker();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_packets();
      test_wheel_packets();
      test_five_button_packets();
      test_id_change_mid_packet();
      test_clamping();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      repeat (10) @(posedge clock);
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/pmpt_pkg.sv
sv/pmpt_csr.sv
sv/ps2_mouse_packet_tracker.sv
tb/tb_ps2_mouse_packet_tracker.sv
